>>> rtl/core/slc_pkg.sv
package slc_pkg;

  // Widths fixed by the item fields.
  localparam int VALUE_W       = 32;
  localparam int ENTRY_COUNT_W = 5;

  // Action codes.
  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_COMPARE = 1'b1;

  // List select codes.
  localparam logic SEL_FIRST  = 1'b0;
  localparam logic SEL_SECOND = 1'b1;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                      ins_a;
    logic                      ins_b;
    logic signed [VALUE_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> rtl/core/slc_cell.sv
module slc_cell (
  input  logic                              clk,
  input  slc_pkg::cell_ctrl_t               ctrl,
  input  logic                              in_range_a,
  input  logic                              in_range_b,
  input  logic signed [slc_pkg::VALUE_W-1:0] prev_val_a,
  input  logic                              prev_gt_a,
  input  logic signed [slc_pkg::VALUE_W-1:0] prev_val_b,
  input  logic                              prev_gt_b,
  output logic signed [slc_pkg::VALUE_W-1:0] val_a,
  output logic                              gt_a,
  output logic signed [slc_pkg::VALUE_W-1:0] val_b,
  output logic                              gt_b,
  output logic                              diff
);
  import slc_pkg::*;

  logic signed [VALUE_W-1:0] val_a_r, val_a_nxt;
  logic signed [VALUE_W-1:0] val_b_r, val_b_nxt;
  logic                      diff_r;

  // An empty slot counts as larger than any value, so the new value lands
  // at the first larger entry or at the end of the list.
  assign gt_a = !in_range_a || (val_a_r > ctrl.value);
  assign gt_b = !in_range_b || (val_b_r > ctrl.value);

  // Take the new value at the insertion point, the left neighbor's entry
  // beyond it, and keep the entry below it.
  always_comb begin
    val_a_nxt = val_a_r;
    val_b_nxt = val_b_r;
    if (ctrl.ins_a && gt_a) begin
      val_a_nxt = prev_gt_a ? prev_val_a : ctrl.value;
    end
    if (ctrl.ins_b && gt_b) begin
      val_b_nxt = prev_gt_b ? prev_val_b : ctrl.value;
    end
  end

  // Entry storage and the mismatch bit between the two lists at this slot.
  always_ff @(posedge clk) begin
    val_a_r <= val_a_nxt;
    val_b_r <= val_b_nxt;
    diff_r  <= (val_a_nxt != val_b_nxt);
  end

  assign val_a = val_a_r;
  assign val_b = val_b_r;
  assign diff  = diff_r;

endmodule

>>> rtl/core/sorted_list_insert_compare_core.sv
// The result of an item is registered and appears in the cycle after its start transfer.
// Throughput: one item per cycle; busy stays low, since every cell of the
// compare-and-shift chain updates its entry in the same cycle.
// Reset (rst_n low, synchronous) empties both lists and clears the strobe.
// The receiver cannot stall; each result is shown for one cycle only.
module sorted_list_insert_compare_core #(
  parameter int LIST_DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic                                    in_action,
  input  logic                                    in_list_sel,
  input  logic signed [slc_pkg::VALUE_W-1:0]      in_value,
  output logic                                    out_valid,
  output logic                                    out_lists_equal,
  output logic                                    out_overflow,
  output logic        [slc_pkg::ENTRY_COUNT_W-1:0] out_entry_count
);
  import slc_pkg::*;

  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic [CNT_W-1:0] cnt_a_r, cnt_a_nxt;
  logic [CNT_W-1:0] cnt_b_r, cnt_b_nxt;
  logic             out_valid_r;
  logic             out_lists_equal_r, out_lists_equal_nxt;
  logic             out_overflow_r, out_overflow_nxt;
  logic [ENTRY_COUNT_W-1:0] out_entry_count_r, out_entry_count_nxt;

  logic       accept;
  logic       full_sel;
  logic       mismatch;
  cell_ctrl_t ctrl;

  logic [LIST_DEPTH-1:0]            in_range_a, in_range_b;
  logic [LIST_DEPTH-1:0]            gt_a, gt_b, diff;
  logic signed [VALUE_W-1:0]        val_a [LIST_DEPTH];
  logic signed [VALUE_W-1:0]        val_b [LIST_DEPTH];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // An insert into a full list is dropped.
  assign full_sel = (in_list_sel == SEL_SECOND) ? (cnt_b_r == CNT_W'(LIST_DEPTH))
                                                : (cnt_a_r == CNT_W'(LIST_DEPTH));

  // Control broadcast to the cells.
  always_comb begin
    ctrl.value = in_value;
    ctrl.ins_a = accept && (in_action == ACT_INSERT) && (in_list_sel == SEL_FIRST)
                 && !full_sel;
    ctrl.ins_b = accept && (in_action == ACT_INSERT) && (in_list_sel == SEL_SECOND)
                 && !full_sel;
  end

  // The chain of cells; each takes its left neighbor's entry on a shift.
  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    assign in_range_a[i] = (CNT_W'(i) < cnt_a_r);
    assign in_range_b[i] = (CNT_W'(i) < cnt_b_r);

    if (i == 0) begin : g_head
      slc_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .in_range_a (in_range_a[i]),
        .in_range_b (in_range_b[i]),
        .prev_val_a (in_value),
        .prev_gt_a  (1'b0),
        .prev_val_b (in_value),
        .prev_gt_b  (1'b0),
        .val_a      (val_a[i]),
        .gt_a       (gt_a[i]),
        .val_b      (val_b[i]),
        .gt_b       (gt_b[i]),
        .diff       (diff[i])
      );
    end else begin : g_body
      slc_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .in_range_a (in_range_a[i]),
        .in_range_b (in_range_b[i]),
        .prev_val_a (val_a[i-1]),
        .prev_gt_a  (gt_a[i-1]),
        .prev_val_b (val_b[i-1]),
        .prev_gt_b  (gt_b[i-1]),
        .val_a      (val_a[i]),
        .gt_a       (gt_a[i]),
        .val_b      (val_b[i]),
        .gt_b       (gt_b[i]),
        .diff       (diff[i])
      );
    end
  end

  // Any differing slot below the shared count makes the lists unequal.
  assign mismatch = |(diff & in_range_a);

  // Counts and the result of the accepted item.
  always_comb begin
    cnt_a_nxt = cnt_a_r + CNT_W'(ctrl.ins_a);
    cnt_b_nxt = cnt_b_r + CNT_W'(ctrl.ins_b);
    out_lists_equal_nxt = (in_action == ACT_COMPARE) && (cnt_a_r == cnt_b_r) && !mismatch;
    out_overflow_nxt    = (in_action == ACT_INSERT) && full_sel;
    out_entry_count_nxt = (in_list_sel == SEL_SECOND) ? ENTRY_COUNT_W'(cnt_b_nxt)
                                                      : ENTRY_COUNT_W'(cnt_a_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        cnt_a_r <= cnt_a_nxt;
        cnt_b_r <= cnt_b_nxt;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_lists_equal_r <= out_lists_equal_nxt;
      out_overflow_r    <= out_overflow_nxt;
      out_entry_count_r <= out_entry_count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_lists_equal = out_lists_equal_r;
  assign out_overflow    = out_overflow_r;
  assign out_entry_count = out_entry_count_r;

  // A result strobe follows a transfer in the previous cycle.
  a_strobe_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept))
    else $error("result strobe without a preceding transfer");

  // Counts never exceed the list depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CNT_W'(LIST_DEPTH)) && (cnt_b_r <= CNT_W'(LIST_DEPTH)))
    else $error("list count beyond depth");

  // An overflow reports a full list.
  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_overflow) |-> (out_entry_count == ENTRY_COUNT_W'(LIST_DEPTH)))
    else $error("overflow with a list that is not full");

  // Equality and overflow belong to different actions.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_lists_equal && out_overflow))
    else $error("equal and overflow flags both set");

endmodule

>>> test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slc_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int RANDOM_ITEMS = 1650;
  localparam int STALL_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

  // One operation waiting for the driver, with the chance of idling before it.
  typedef struct {
    logic                      action;
    logic                      list_sel;
    logic signed [VALUE_W-1:0] value;
    int unsigned               idle_pct;
  } list_op_t;

  typedef struct packed {
    logic                     lists_equal;
    logic                     overflow;
    logic [ENTRY_COUNT_W-1:0] entry_count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = ACT_INSERT;
  logic in_list_sel = SEL_FIRST;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_lists_equal;
  logic out_overflow;
  logic [ENTRY_COUNT_W-1:0] out_entry_count;

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];

  // Shadow copy of both sorted lists.
  logic signed [VALUE_W-1:0] sorted_vals [2][LIST_DEPTH];
  int unsigned               sorted_count [2];

  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;

  sorted_list_insert_compare_core #(
    .LIST_DEPTH(LIST_DEPTH)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_list_sel     (in_list_sel),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_lists_equal (out_lists_equal),
    .out_overflow    (out_overflow),
    .out_entry_count (out_entry_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Applies one operation to the shadow lists and returns its result.
  function automatic list_result_t predict_list_result(logic action, logic list_sel,
                                                       logic signed [VALUE_W-1:0] value);
    list_result_t res;
    int unsigned  pos;
    int unsigned  k;
    int unsigned  idx;
    res = '0;
    idx = (list_sel == SEL_SECOND) ? 1 : 0;
    if (action == ACT_INSERT) begin
      if (sorted_count[idx] >= LIST_DEPTH) begin
        res.overflow = 1'b1;
      end else begin
        // New value goes in front of the first strictly larger entry.
        pos = 0;
        while (pos < sorted_count[idx] && sorted_vals[idx][pos] <= value) pos++;
        for (k = sorted_count[idx]; k > pos; k--) sorted_vals[idx][k] = sorted_vals[idx][k-1];
        sorted_vals[idx][pos] = value;
        sorted_count[idx]++;
      end
    end else begin
      res.lists_equal = (sorted_count[0] == sorted_count[1]);
      for (k = 0; k < sorted_count[0] && res.lists_equal; k++) begin
        if (sorted_vals[0][k] != sorted_vals[1][k]) res.lists_equal = 1'b0;
      end
    end
    res.entry_count = sorted_count[idx][ENTRY_COUNT_W-1:0];
    return res;
  endfunction

  function automatic void note_error(string msg);
    if (error_count < MAX_REPORTS) $display("%s", msg);
    error_count++;
  endfunction

  function automatic void push_op(logic action, logic list_sel,
                                 logic signed [VALUE_W-1:0] value, int unsigned idle_pct);
    list_op_t op;
    op.action   = action;
    op.list_sel = list_sel;
    op.value    = value;
    op.idle_pct = idle_pct;
    pending_ops.push_back(op);
  endfunction

  // Mix of extremes, a narrow band around zero (many equal values) and full range.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: v = VALUE_MIN;
          1: v = VALUE_MAX;
          2: v = '0;
          default: v = -1;
        endcase
      end
      1: v = $signed($urandom_range(6)) - 3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Driver: a new operation is offered once the current one has transferred.
  always @(posedge clk) begin : drive_blk
    list_op_t op;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= pending_ops[0].idle_pct) begin
        op = pending_ops.pop_front();
        start       <= 1'b1;
        in_action   <= op.action;
        in_list_sel <= op.list_sel;
        in_value    <= op.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check each result against the oldest prediction, then predict
  // the operation that transfers at this edge.
  always @(posedge clk) begin : check_blk
    list_result_t got;
    list_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        got.lists_equal = out_lists_equal;
        got.overflow    = out_overflow;
        got.entry_count = out_entry_count;
        if (expected_results.size() == 0) begin
          note_error($sformatf("Unexpected result: equal=%0b overflow=%0b count=%0d",
                               got.lists_equal, got.overflow, got.entry_count));
        end else begin
          want = expected_results.pop_front();
          if (got.lists_equal !== want.lists_equal || got.overflow !== want.overflow ||
              got.entry_count !== want.entry_count) begin
            note_error($sformatf({"Mismatch: expected equal=%0b overflow=%0b count=%0d, ",
                                  "got equal=%0b overflow=%0b count=%0d"},
                                 want.lists_equal, want.overflow, want.entry_count,
                                 got.lists_equal, got.overflow, got.entry_count));
          end
        end
      end
      if (start && !busy) begin
        expected_results.push_back(predict_list_result(in_action, in_list_sel, in_value));
      end
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_blk
    int unsigned n_items;
    int unsigned roll;
    int unsigned idle_pct;
    logic        first_sel;
    logic signed [VALUE_W-1:0] v;

    sorted_count[0] = 0;
    sorted_count[1] = 0;

    // Directed: empty lists, extremes, unequal length, unequal contents,
    // equal values landing after their peers, and lists becoming equal again.
    push_op(ACT_COMPARE, SEL_FIRST,  VALUE_MAX, 0);
    push_op(ACT_COMPARE, SEL_SECOND, VALUE_MIN, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  VALUE_MAX, 0);
    push_op(ACT_COMPARE, SEL_FIRST,  '0, 0);
    push_op(ACT_INSERT,  SEL_SECOND, VALUE_MIN, 0);
    push_op(ACT_COMPARE, SEL_SECOND, '0, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  VALUE_MIN, 0);
    push_op(ACT_INSERT,  SEL_SECOND, VALUE_MAX, 0);
    push_op(ACT_COMPARE, SEL_SECOND, -1, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  5, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  5, 0);
    push_op(ACT_INSERT,  SEL_SECOND, 5, 0);
    push_op(ACT_INSERT,  SEL_SECOND, 5, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  -1, 0);
    push_op(ACT_INSERT,  SEL_SECOND, -1, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  '0, 0);
    push_op(ACT_INSERT,  SEL_SECOND, '0, 0);
    push_op(ACT_COMPARE, SEL_FIRST,  '0, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  VALUE_MAX, 0);
    push_op(ACT_INSERT,  SEL_SECOND, VALUE_MIN, 0);
    push_op(ACT_COMPARE, SEL_FIRST,  '0, 0);
    push_op(ACT_INSERT,  SEL_FIRST,  VALUE_MIN, 0);
    push_op(ACT_INSERT,  SEL_SECOND, VALUE_MAX, 0);
    push_op(ACT_COMPARE, SEL_SECOND, '0, 0);

    // Random: mostly mirrored inserts that keep the lists equal, some lone
    // inserts that break them, and compares. Both lists fill up and then
    // every insert overflows. Sender idling changes by phase.
    n_items = 0;
    while (n_items < RANDOM_ITEMS) begin
      case ((n_items * 4) / RANDOM_ITEMS)
        1: idle_pct = 84;
        2: idle_pct = 6;
        default: idle_pct = 0;
      endcase
      roll = $urandom_range(99);
      if (roll < 30) begin
        v = pick_value();
        first_sel = 1'($urandom_range(1));
        push_op(ACT_INSERT, first_sel, v, idle_pct);
        push_op(ACT_INSERT, !first_sel, v, idle_pct);
        n_items += 2;
      end else if (roll < 40) begin
        push_op(ACT_INSERT, 1'($urandom_range(1)), pick_value(), idle_pct);
        n_items++;
      end else begin
        push_op(ACT_COMPARE, 1'($urandom_range(1)), $urandom, idle_pct);
        n_items++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all operations transferred, all results back, then a short tail.
    @(negedge clk);
    while (pending_ops.size() > 0 || start) @(negedge clk);
    while (expected_results.size() > 0) @(negedge clk);
    repeat (5) @(negedge clk);

    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
